// ===== src/mfr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the meter frame receiver: payload structs, phase and status codes,
// register indexes and reset values. No dependencies.
package mfr_pkg;

  // Field widths fixed by the frame format
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_BYTES = 6;
  localparam int unsigned ADDR_W     = BYTE_W * ADDR_BYTES;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // Depth of the queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_DELIM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_DELIM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 2'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] RST_START_DELIM = 8'h68;
  localparam logic [BYTE_W-1:0] RST_MID_DELIM   = 8'h68;
  localparam logic [BYTE_W-1:0] RST_END_DELIM   = 8'h16;
  localparam logic [BYTE_W-1:0] RST_DATA_OFFSET = 8'h33;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SUM     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_END     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOSTART = 3'd5;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_MID,
    PH_CTRL,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_END
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              chunk_end;
  } in_t;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   byte_pos;
    logic [ADDR_W-1:0]   meter_address;
    logic [4:0]          func_code;
    logic                from_slave;
    logic                abnormal;
    logic                follow_frame;
    logic [BYTE_W-1:0]   data_len;
    logic [STATUS_W-1:0] frame_status;
    logic                last;
  } out_t;

  // Delimiters used by the parser
  typedef struct packed {
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] mid_delim;
    logic [BYTE_W-1:0] end_delim;
  } delim_cfg_t;

  // One classified result waiting in the queue
  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   raw_byte;
    logic [BYTE_W-1:0]   byte_pos;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   ctrl;
    logic [BYTE_W-1:0]   len;
    logic [STATUS_W-1:0] status;
  } q_entry_t;

endpackage

// ===== src/mfr_front.sv =====
`timescale 1ns / 1ps
// Frame parser: walks the frame phases on every accepted byte and emits
// classified results into the queue. Depends on mfr_pkg.
module mfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  mfr_pkg::in_t         in_data,
  input  mfr_pkg::delim_cfg_t  dcfg,
  output logic                 q_push,
  output mfr_pkg::q_entry_t    q_entry
);

  mfr_pkg::phase_t                   phase_r, phase_nxt;
  logic [mfr_pkg::ADDR_W-1:0]        addr_r, addr_nxt;
  logic [mfr_pkg::BYTE_W-1:0]        ctrl_r, ctrl_nxt;
  logic [mfr_pkg::BYTE_W-1:0]        len_r, len_nxt;
  logic [mfr_pkg::BYTE_W-1:0]        cnt_r, cnt_nxt;
  logic [mfr_pkg::BYTE_W-1:0]        sum_r, sum_nxt;
  logic                              drop_r, drop_nxt;

  logic [mfr_pkg::BYTE_W-1:0]        b;
  logic                              cend;
  logic [mfr_pkg::BYTE_W:0]          cnt_inc;
  logic                              fin;
  logic                              data_res;
  logic [mfr_pkg::STATUS_W-1:0]      fin_st;

  assign b       = in_data.rx_byte;
  assign cend    = in_data.chunk_end;
  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  // Advance the frame phase and collect header fields
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    ctrl_nxt  = ctrl_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    drop_nxt  = drop_r;
    fin       = 1'b0;
    fin_st    = mfr_pkg::ST_OK;
    data_res  = 1'b0;
    if (acc) begin
      if (drop_r) begin
        if (cend) begin
          drop_nxt  = 1'b0;
          phase_nxt = mfr_pkg::PH_HUNT;
        end
      end else begin
        case (phase_r)
          mfr_pkg::PH_ADDR: begin
            for (int i = 0; i < int'(mfr_pkg::ADDR_BYTES); i++) begin
              if (cnt_r[2:0] == 3'(i)) begin
                addr_nxt[8*i +: 8] = addr_r[8*i +: 8] | b;
              end
            end
            sum_nxt = sum_r + b;
            cnt_nxt = cnt_inc[mfr_pkg::BYTE_W-1:0];
            if (cnt_r == 8'(mfr_pkg::ADDR_BYTES - 1)) begin
              phase_nxt = mfr_pkg::PH_MID;
            end
            if (cend) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_TRUNC;
            end
          end
          mfr_pkg::PH_MID: begin
            if (b != dcfg.mid_delim) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_MID;
            end else begin
              sum_nxt   = sum_r + b;
              phase_nxt = mfr_pkg::PH_CTRL;
              if (cend) begin
                fin    = 1'b1;
                fin_st = mfr_pkg::ST_TRUNC;
              end
            end
          end
          mfr_pkg::PH_CTRL: begin
            ctrl_nxt  = b;
            sum_nxt   = sum_r + b;
            phase_nxt = mfr_pkg::PH_LEN;
            if (cend) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_TRUNC;
            end
          end
          mfr_pkg::PH_LEN: begin
            len_nxt   = b;
            sum_nxt   = sum_r + b;
            cnt_nxt   = '0;
            phase_nxt = (b == '0) ? mfr_pkg::PH_SUM : mfr_pkg::PH_DATA;
            if (cend) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_TRUNC;
            end
          end
          mfr_pkg::PH_DATA: begin
            sum_nxt = sum_r + b;
            cnt_nxt = cnt_inc[mfr_pkg::BYTE_W-1:0];
            if (cnt_inc >= {1'b0, len_r}) begin
              phase_nxt = mfr_pkg::PH_SUM;
            end
            if (cend) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_TRUNC;
            end else begin
              data_res = 1'b1;
            end
          end
          mfr_pkg::PH_SUM: begin
            if (b != sum_r) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_SUM;
            end else begin
              phase_nxt = mfr_pkg::PH_END;
              if (cend) begin
                fin    = 1'b1;
                fin_st = mfr_pkg::ST_TRUNC;
              end
            end
          end
          mfr_pkg::PH_END: begin
            fin    = 1'b1;
            fin_st = (b == dcfg.end_delim) ? mfr_pkg::ST_OK : mfr_pkg::ST_END;
          end
          default: begin
            // Hunt for the start delimiter
            if (b == dcfg.start_delim) begin
              addr_nxt  = '0;
              ctrl_nxt  = '0;
              len_nxt   = '0;
              cnt_nxt   = '0;
              sum_nxt   = b;
              phase_nxt = mfr_pkg::PH_ADDR;
              if (cend) begin
                fin    = 1'b1;
                fin_st = mfr_pkg::ST_TRUNC;
              end
            end else if (cend) begin
              fin    = 1'b1;
              fin_st = mfr_pkg::ST_NOSTART;
            end
          end
        endcase
        // Close the frame: back to hunting, drop the rest of a chunk
        if (fin) begin
          phase_nxt = mfr_pkg::PH_HUNT;
          drop_nxt  = !cend;
        end
      end
    end
  end

  // Build the queue entry from the updated header fields
  always_comb begin
    q_push           = fin | data_res;
    q_entry.kind     = fin ? mfr_pkg::KIND_STATUS : mfr_pkg::KIND_DATA;
    q_entry.raw_byte = b;
    q_entry.byte_pos = fin ? '0 : cnt_r;
    q_entry.addr     = addr_nxt;
    q_entry.ctrl     = ctrl_nxt;
    q_entry.len      = len_nxt;
    q_entry.status   = fin ? fin_st : mfr_pkg::ST_OK;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mfr_pkg::PH_HUNT;
      addr_r  <= '0;
      ctrl_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      ctrl_r  <= ctrl_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Dropping only ever happens between frames
  a_drop_hunt : assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> phase_r == mfr_pkg::PH_HUNT)
    else $error("dropping chunk while inside a frame");

  // A status result always returns the parser to hunting
  a_status_hunt : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_entry.kind == mfr_pkg::KIND_STATUS) |=> phase_r == mfr_pkg::PH_HUNT)
    else $error("status result without return to hunting");

endmodule

// ===== src/mfr_fifo.sv =====
`timescale 1ns / 1ps
// Short register queue between the parser and the output stage.
// Depends on nothing outside itself.
module mfr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== src/mfr_back.sv =====
`timescale 1ns / 1ps
// Output stage: takes entries from the queue, removes the data offset and
// splits the control byte into the result register. Depends on mfr_pkg.
module mfr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfr_pkg::q_entry_t           q_entry,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [mfr_pkg::BYTE_W-1:0]  data_offset,
  output mfr_pkg::out_t               out_data,
  output logic                        out_empty,
  input  logic                        out_pop
);

  mfr_pkg::out_t res_nxt;
  mfr_pkg::out_t res_r;
  logic          valid_r;

  // Load a new result whenever the queue holds one and the output register is free or being taken
  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_data  = res_r;

  // Format the result
  always_comb begin
    res_nxt.kind          = q_entry.kind;
    res_nxt.data_byte     = (q_entry.kind == mfr_pkg::KIND_DATA) ?
                            q_entry.raw_byte - data_offset : '0;
    res_nxt.byte_pos      = q_entry.byte_pos;
    res_nxt.meter_address = q_entry.addr;
    res_nxt.func_code     = q_entry.ctrl[4:0];
    res_nxt.from_slave    = q_entry.ctrl[7];
    res_nxt.abnormal      = q_entry.ctrl[6];
    res_nxt.follow_frame  = q_entry.ctrl[5];
    res_nxt.data_len      = q_entry.len;
    res_nxt.frame_status  = q_entry.status;
    res_nxt.last          = (q_entry.kind == mfr_pkg::KIND_STATUS);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  // A result is never taken from the queue while the output is still held
  a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_pop) |-> !q_pop)
    else $error("result register overwritten before it was taken");

endmodule

// ===== src/meter_frame_receiver.sv =====
`timescale 1ns / 1ps
// Meter frame receiver top level: configuration registers, parser, queue
// and output stage. Depends on mfr_pkg, mfr_front, mfr_fifo, mfr_back.
// A result passes through the result queue and then the output register.
// Throughput: one byte per cycle while full is low; full rises only when
// every entry of the result queue (QDEPTH entries) is occupied.
// Reset (synchronous, rst_n low): parser hunts for a start byte, queue and
// output are emptied, registers return to their defaults.
module meter_frame_receiver #(
  parameter int unsigned QDEPTH = mfr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  mfr_pkg::in_t                   in_data,
  output logic                           empty,
  input  logic                           pop,
  output mfr_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfr_pkg::BYTE_W-1:0]     cfg_wdata
);

  mfr_pkg::delim_cfg_t          dcfg_r;
  logic [mfr_pkg::BYTE_W-1:0]   offset_r;
  logic                         acc;
  logic                         q_push, q_pop, q_full, q_empty;
  mfr_pkg::q_entry_t            q_wentry, q_rentry;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcfg_r.start_delim <= mfr_pkg::RST_START_DELIM;
      dcfg_r.mid_delim   <= mfr_pkg::RST_MID_DELIM;
      dcfg_r.end_delim   <= mfr_pkg::RST_END_DELIM;
      offset_r           <= mfr_pkg::RST_DATA_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        mfr_pkg::CFG_START_DELIM: dcfg_r.start_delim <= cfg_wdata;
        mfr_pkg::CFG_MID_DELIM:   dcfg_r.mid_delim   <= cfg_wdata;
        mfr_pkg::CFG_END_DELIM:   dcfg_r.end_delim   <= cfg_wdata;
        mfr_pkg::CFG_DATA_OFFSET: offset_r           <= cfg_wdata;
        default:                  offset_r           <= offset_r;
      endcase
    end
  end

  assign full = q_full;
  assign acc  = push && !q_full;

  mfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .dcfg    (dcfg_r),
    .q_push  (q_push),
    .q_entry (q_wentry)
  );

  mfr_fifo #(
    .WIDTH ($bits(mfr_pkg::q_entry_t)),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wentry),
    .pop   (q_pop),
    .rdata (q_rentry),
    .full  (q_full),
    .empty (q_empty)
  );

  mfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_entry     (q_rentry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .data_offset (offset_r),
    .out_data    (out_data),
    .out_empty   (empty),
    .out_pop     (pop)
  );

endmodule
